FILE: rtl/pcmiec_pkg.sv
// Package for the PCM to IEC958 sample formatter.
// Holds format codes, register indexes, widths and the configuration struct.
// No dependencies; every RTL file of the block imports it.
`default_nettype none

package pcmiec_pkg;

   // Frame counter and channel status sizes
   localparam int FRAMES_PER_BLOCK = 192;
   localparam int STATUS_BITS      = 40;
   localparam int POS_W            = 8;
   localparam int STATUS_IDX_W     = $clog2(STATUS_BITS);

   // Field and register widths
   localparam int SAMPLE_W   = 32;
   localparam int FMT_W      = 2;
   localparam int SCALE_W    = 31;
   localparam int CSR_DATA_W = 40;
   localparam int CSR_IDX_W  = 3;

   // Input format codes
   localparam logic [FMT_W-1:0] IN_U8     = 2'd0;
   localparam logic [FMT_W-1:0] IN_S16    = 2'd1;
   localparam logic [FMT_W-1:0] IN_S24    = 2'd2;
   localparam logic [FMT_W-1:0] IN_S24_32 = 2'd3;

   // Output format codes
   localparam logic [FMT_W-1:0] OUT_S16    = 2'd0;
   localparam logic [FMT_W-1:0] OUT_S24_32 = 2'd1;
   localparam logic [FMT_W-1:0] OUT_UNS    = 2'd2;
   localparam logic [FMT_W-1:0] OUT_IEC    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_INPUT_FORMAT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_OUTPUT_FORMAT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MONO_INPUT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SWAP_SLOTS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_FULL_SCALE    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STATUS_BITS   = 3'd5;

   // Reset values
   localparam logic [SCALE_W-1:0] FULL_SCALE_RST = 31'h7FFF_FFFF;

   // Configuration as seen by the datapath
   typedef struct packed {
      logic [FMT_W-1:0]       input_format;
      logic [FMT_W-1:0]       output_format;
      logic                   mono_input;
      logic                   swap_slots;
      logic [SCALE_W-1:0]     unsigned_full_scale;
      logic [STATUS_BITS-1:0] channel_status_bits;
   } cfg_type;

endpackage

`default_nettype wire

FILE: rtl/pcm_to_iec958_sample_formatter_top.sv
// Top level of the PCM to IEC958 sample formatter.
// Uses pcmiec_pkg, pcmiec_csr (registers) and pcmiec_conv (two converters).
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, req_first_sample, | in
//           | req_second_sample                       |
//   rsp     | rsp_valid, rsp_stall, rsp_subframe_word,| out
//           | rsp_block_start, rsp_slot, rsp_last     |
//   csr     | csr_write, csr_index, csr_data          | in
//
// Each item passes an input register, then both subframes are formed
// combinationally into a result register pair, which is delivered slot 0 then
// slot 1; the pair frees only after slot 1 is taken. Reset (synchronous)
// clears valids and the frame counter and loads the configuration defaults.
// Stall on rsp holds the result pair; the input register takes one more item
// while the pair waits.
`default_nettype none

module pcm_to_iec958_sample_formatter_top
   import pcmiec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [SAMPLE_W-1:0]   req_first_sample,
   input  wire logic [SAMPLE_W-1:0]   req_second_sample,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic      [SAMPLE_W-1:0]   rsp_subframe_word,
   output logic                       rsp_block_start,
   output logic                       rsp_slot,
   output logic                       rsp_last,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type cfg;

   logic                in_valid_ff;
   logic [SAMPLE_W-1:0] in_first_ff;
   logic [SAMPLE_W-1:0] in_second_ff;
   logic                in_status_ff;
   logic                in_bstart_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [POS_W-1:0]    pos_in;

   logic                out_valid_ff;
   logic                out_phase_ff;
   logic [SAMPLE_W-1:0] out_word0_ff;
   logic [SAMPLE_W-1:0] out_word1_ff;
   logic                out_bstart_ff;

   logic                iec;
   logic                status;
   logic                req_take;
   logic                rsp_take;
   logic                out_free;
   logic                move;
   logic [SAMPLE_W-1:0] word_a;
   logic [SAMPLE_W-1:0] word_b_raw;
   logic [SAMPLE_W-1:0] word_b;

   pcmiec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Handshake: the result pair frees after slot 1 is taken
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign out_free  = !out_valid_ff || (rsp_take && out_phase_ff);
   assign move      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Frame counter and status bit pick, IEC958 mode only
   assign iec    = (cfg.output_format == OUT_IEC);
   assign status = iec && (pos_ff < POS_W'(STATUS_BITS))
                   && cfg.channel_status_bits[pos_ff[STATUS_IDX_W-1:0]];

   always_comb begin
      pos_in = pos_ff;
      if (req_take && iec) begin
         if (pos_ff == POS_W'(FRAMES_PER_BLOCK - 1)) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pos_ff      <= '0;
      end else begin
         pos_ff <= pos_in;
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (move) begin
            in_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_first_ff  <= req_first_sample;
         in_second_ff <= req_second_sample;
         in_status_ff <= status;
         in_bstart_ff <= iec && (pos_ff == '0);
      end
   end

   // Conversion of both samples
   pcmiec_conv u_conv_a (
      .raw           (in_first_ff),
      .input_format  (cfg.input_format),
      .output_format (cfg.output_format),
      .full_scale    (cfg.unsigned_full_scale),
      .status        (in_status_ff),
      .word          (word_a)
   );

   pcmiec_conv u_conv_b (
      .raw           (in_second_ff),
      .input_format  (cfg.input_format),
      .output_format (cfg.output_format),
      .full_scale    (cfg.unsigned_full_scale),
      .status        (in_status_ff),
      .word          (word_b_raw)
   );

   assign word_b = cfg.mono_input ? word_a : word_b_raw;

   // Result register pair with slot phase
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_phase_ff <= 1'b0;
      end else begin
         if (move) begin
            out_valid_ff <= 1'b1;
            out_phase_ff <= 1'b0;
         end else if (rsp_take) begin
            if (out_phase_ff) begin
               out_valid_ff <= 1'b0;
               out_phase_ff <= 1'b0;
            end else begin
               out_phase_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         out_word0_ff  <= cfg.swap_slots ? word_b : word_a;
         out_word1_ff  <= cfg.swap_slots ? word_a : word_b;
         out_bstart_ff <= in_bstart_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_subframe_word = out_phase_ff ? out_word1_ff : out_word0_ff;
   assign rsp_block_start   = out_bstart_ff;
   assign rsp_slot          = out_phase_ff;
   assign rsp_last          = out_phase_ff;

endmodule

`default_nettype wire

FILE: rtl/pcmiec_csr.sv
// Configuration registers of the PCM to IEC958 formatter.
// Depends on pcmiec_pkg for register indexes, reset values and cfg_type.
`default_nettype none

module pcmiec_csr
   import pcmiec_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode; unknown indexes are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_INPUT_FORMAT:  cfg_in.input_format  = csr_data[FMT_W-1:0];
            REG_OUTPUT_FORMAT: cfg_in.output_format = csr_data[FMT_W-1:0];
            REG_MONO_INPUT:    cfg_in.mono_input    = csr_data[0];
            REG_SWAP_SLOTS:    cfg_in.swap_slots    = csr_data[0];
            REG_FULL_SCALE:    cfg_in.unsigned_full_scale = csr_data[SCALE_W-1:0];
            REG_STATUS_BITS:   cfg_in.channel_status_bits = csr_data[STATUS_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.input_format        <= IN_S16;
         cfg_ff.output_format       <= OUT_S16;
         cfg_ff.mono_input          <= 1'b0;
         cfg_ff.swap_slots          <= 1'b0;
         cfg_ff.unsigned_full_scale <= FULL_SCALE_RST;
         cfg_ff.channel_status_bits <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/pcmiec_conv.sv
// Sample converter: widens one raw sample to 32-bit signed and narrows it
// to the hardware word format. Pure logic. Depends on pcmiec_pkg.
`default_nettype none

module pcmiec_conv
   import pcmiec_pkg::*;
(
   input  wire logic [SAMPLE_W-1:0] raw,
   input  wire logic [FMT_W-1:0]    input_format,
   input  wire logic [FMT_W-1:0]    output_format,
   input  wire logic [SCALE_W-1:0]  full_scale,
   input  wire logic                status,
   output logic      [SAMPLE_W-1:0] word
);

   logic [SAMPLE_W-1:0]         wide;
   logic [SAMPLE_W-1:0]         offset;
   logic [SAMPLE_W+SCALE_W-1:0] product;
   logic [SAMPLE_W-1:0]         iec;

   // Widen: unsigned 8 is recentered by flipping its top bit
   always_comb begin
      case (input_format)
         IN_U8:   wide = {raw[7] ^ 1'b1, raw[6:0], 24'd0};
         IN_S16:  wide = {raw[15:0], 16'd0};
         default: wide = {raw[23:0], 8'd0};
      endcase
   end

   // Unsigned scaling: (wide + 2^31) * full_scale, top 31 bits of 63
   assign offset  = {~wide[31], wide[30:0]};
   assign product = offset * full_scale;

   // IEC958 subframe: sample in 27:4, status in 30, even parity in 31
   always_comb begin
      iec        = '0;
      iec[27:4]  = wide[31:8];
      iec[30]    = status;
      iec[31]    = ^iec[30:0];
   end

   always_comb begin
      case (output_format)
         OUT_S16:    word = {16'd0, wide[31:16]};
         OUT_S24_32: word = {{8{wide[31]}}, wide[31:8]};
         OUT_UNS:    word = {1'b0, product[SAMPLE_W+SCALE_W-1:SAMPLE_W]};
         default:    word = iec;
      endcase
   end

endmodule

`default_nettype wire
